FILE: hw/rtl/isel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package isel_pkg;

	localparam int MAX_CAND = 64;
	localparam int IDX_W    = $clog2(MAX_CAND);
	localparam int CNT_W    = $clog2(MAX_CAND + 1);
	localparam int DATA_W   = 32;
	localparam int CFG_W    = 7;
	localparam int MAT_AW   = 2 * IDX_W;

	localparam logic [1:0] CMD_FIT = 2'd0;
	localparam logic [1:0] CMD_MAT = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_KEEP  = 1'b1;

	localparam logic [CFG_W-1:0] TOTAL_RST = CFG_W'(64);
	localparam logic [CFG_W-1:0] KEEP_RST  = CFG_W'(32);

	typedef struct packed {
		logic                     gt;
		logic signed [DATA_W-1:0] diff;
	} unit_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/isel_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module isel_unit (
	input  wire logic signed [isel_pkg::DATA_W-1:0] a,
	input  wire logic signed [isel_pkg::DATA_W-1:0] b,
	output isel_pkg::unit_res_t                     res
);

	logic signed [isel_pkg::DATA_W:0] d;

	assign d = {a[isel_pkg::DATA_W-1], a} - {b[isel_pkg::DATA_W-1], b};

	always_comb begin
		res.gt = ~d[isel_pkg::DATA_W] & (d != '0);
		if (d[isel_pkg::DATA_W] != d[isel_pkg::DATA_W-1]) begin
			// saturate toward the sign of the exact difference
			res.diff = d[isel_pkg::DATA_W] ? {1'b1, {(isel_pkg::DATA_W-1){1'b0}}}
			                               : {1'b0, {(isel_pkg::DATA_W-1){1'b1}}};
		end else begin
			res.diff = d[isel_pkg::DATA_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/indicator_based_survivor_selection.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    command, row_index, col_index, value
// out      out  out_valid/out_ready  survivor_index, survivor_fitness, last_survivor
// cfg      in   cfg_wr_en            cfg_index, cfg_data
//
// Fitness and matrix loads are written into their stores as they are accepted.
// A run does n-keep removal rounds on one shared subtract/compare unit fed by one read
// port per memory, then emits the survivors, waiting while out is not ready.
// in_ready is low from a run's start until the emit walk has passed the last candidate.
// arst_n clears control state and sets total 64, keep 32; stores have no reset value.
module indicator_based_survivor_selection (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          command,
	input  wire logic [5:0]                          row_index,
	input  wire logic [5:0]                          col_index,
	input  wire logic signed [31:0]                  value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [5:0]                               survivor_index,
	output logic signed [31:0]                       survivor_fitness,
	output logic                                     last_survivor,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_index,
	input  wire logic [isel_pkg::CFG_W-1:0]          cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SCAN_END, S_SUB, S_SUB_END, S_EMIT, S_EMIT_RD
	} state_t;

	state_t                                state_q;
	logic [isel_pkg::CFG_W-1:0]            total_q, keep_cfg_q;
	logic [isel_pkg::CNT_W-1:0]            n_q, keep_q, rounds_q, i_q, e_q;
	logic [isel_pkg::CNT_W-1:0]            n_eff, keep_eff;
	logic [isel_pkg::MAX_CAND-1:0]         removed_q;
	logic [isel_pkg::IDX_W-1:0]            worst_q, idx_s1;
	logic signed [isel_pkg::DATA_W-1:0]    best_q;
	logic                                  found_q, vld_s1, skip_s1;
	logic [isel_pkg::IDX_W-1:0]            i_idx;

	logic signed [isel_pkg::DATA_W-1:0]    fit_mem [isel_pkg::MAX_CAND];
	logic signed [isel_pkg::DATA_W-1:0]    mat_mem [isel_pkg::MAX_CAND * isel_pkg::MAX_CAND];
	logic signed [isel_pkg::DATA_W-1:0]    fit_rd_q, mat_rd_q;
	logic                                  fit_we, fit_re, mat_we, mat_re;
	logic [isel_pkg::IDX_W-1:0]            fit_wa;
	logic signed [isel_pkg::DATA_W-1:0]    fit_wd, unit_b;
	logic                                  in_xfer, issue, cmp_ph, sub_ph, out_load;
	isel_pkg::unit_res_t                   ures;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid & in_ready;
	assign i_idx    = i_q[isel_pkg::IDX_W-1:0];

	assign n_eff    = (total_q > isel_pkg::CFG_W'(isel_pkg::MAX_CAND))
	                  ? isel_pkg::CNT_W'(isel_pkg::MAX_CAND) : isel_pkg::CNT_W'(total_q);
	assign keep_eff = (isel_pkg::CNT_W'(keep_cfg_q) > n_eff) ? n_eff
	                  : isel_pkg::CNT_W'(keep_cfg_q);

	assign issue  = (state_q == S_SCAN) | (state_q == S_SUB);
	assign cmp_ph = (state_q == S_SCAN) | (state_q == S_SCAN_END);
	assign sub_ph = (state_q == S_SUB) | (state_q == S_SUB_END);
	assign unit_b = cmp_ph ? best_q : mat_rd_q;
	assign out_load = (state_q == S_EMIT_RD) & (~out_valid | out_ready);

	isel_unit u_unit (
		.a   (fit_rd_q),
		.b   (unit_b),
		.res (ures)
	);

	always_comb begin
		fit_we = 1'b0;
		fit_wa = row_index;
		fit_wd = value;
		if (in_xfer && command == isel_pkg::CMD_FIT) begin
			fit_we = 1'b1;
		end else if (sub_ph && vld_s1 && !skip_s1) begin
			fit_we = 1'b1;
			fit_wa = idx_s1;
			fit_wd = ures.diff;
		end
	end

	assign fit_re = issue |
	                ((state_q == S_EMIT) && (i_q != n_q) && !removed_q[i_idx]);
	assign mat_re = (state_q == S_SUB);
	assign mat_we = in_xfer & (command == isel_pkg::CMD_MAT);

	always_ff @(posedge clk) begin
		if (fit_we) begin
			fit_mem[fit_wa] <= fit_wd;
		end
		if (fit_re) begin
			fit_rd_q <= fit_mem[i_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[{row_index, col_index}] <= value;
		end
		if (mat_re) begin
			mat_rd_q <= mat_mem[{worst_q, i_idx}];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= i_idx;
		skip_s1 <= removed_q[i_idx];
		if (cmp_ph && vld_s1 && !skip_s1 && (!found_q || ures.gt)) begin
			best_q  <= fit_rd_q;
			worst_q <= idx_s1;
		end
		if (out_load) begin
			survivor_index   <= i_idx;
			survivor_fitness <= fit_rd_q;
			last_survivor    <= (e_q == keep_q - isel_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= isel_pkg::TOTAL_RST;
			keep_cfg_q <= isel_pkg::KEEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				isel_pkg::REG_TOTAL: total_q    <= cfg_data;
				isel_pkg::REG_KEEP:  keep_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			keep_q    <= '0;
			rounds_q  <= '0;
			i_q       <= '0;
			e_q       <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmp_ph && vld_s1 && !skip_s1) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && command == isel_pkg::CMD_RUN) begin
						n_q       <= n_eff;
						keep_q    <= keep_eff;
						rounds_q  <= n_eff - keep_eff;
						removed_q <= '0;
						i_q       <= '0;
						e_q       <= '0;
						found_q   <= 1'b0;
						state_q   <= (n_eff == keep_eff) ? S_EMIT : S_SCAN;
					end
				end
				S_SCAN: begin
					if (i_q == n_q - isel_pkg::CNT_W'(1)) begin
						i_q     <= '0;
						state_q <= S_SCAN_END;
					end else begin
						i_q <= i_q + isel_pkg::CNT_W'(1);
					end
				end
				S_SCAN_END: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (i_q == n_q - isel_pkg::CNT_W'(1)) begin
						i_q     <= '0;
						state_q <= S_SUB_END;
					end else begin
						i_q <= i_q + isel_pkg::CNT_W'(1);
					end
				end
				S_SUB_END: begin
					removed_q[worst_q] <= 1'b1;
					rounds_q           <= rounds_q - isel_pkg::CNT_W'(1);
					found_q            <= 1'b0;
					state_q <= (rounds_q == isel_pkg::CNT_W'(1)) ? S_EMIT : S_SCAN;
				end
				S_EMIT: begin
					if (i_q == n_q) begin
						state_q <= S_IDLE;
					end else if (removed_q[i_idx]) begin
						i_q <= i_q + isel_pkg::CNT_W'(1);
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					if (out_load) begin
						i_q     <= i_q + isel_pkg::CNT_W'(1);
						e_q     <= e_q + isel_pkg::CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import isel_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] fit;
		logic                     last;
	} survivor_t;

	typedef struct {
		logic [1:0]               cmd;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] val;
	} load_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               command;
	logic [5:0]               row_index;
	logic [5:0]               col_index;
	logic signed [31:0]       value;
	logic                     out_valid;
	logic                     out_ready;
	logic [5:0]               survivor_index;
	logic signed [31:0]       survivor_fitness;
	logic                     last_survivor;
	logic                     cfg_wr_en;
	logic                     cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	// mirror of the block state
	logic signed [DATA_W-1:0] fit_mem [MAX_CAND];
	bit                       fit_known [MAX_CAND];
	logic signed [DATA_W-1:0] corr_mem [MAX_CAND*MAX_CAND];
	bit                       corr_known [MAX_CAND*MAX_CAND];
	logic [CFG_W-1:0]         cfg_total;
	logic [CFG_W-1:0]         cfg_keep;

	survivor_t survivors_due[$];
	load_t     pending_loads[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;
	int settle_cycles;
	int items_sent;
	int mismatches;
	int quiet_cycles;

	indicator_based_survivor_selection dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.row_index        (row_index),
		.col_index        (col_index),
		.value            (value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.survivor_index   (survivor_index),
		.survivor_fitness (survivor_fitness),
		.last_survivor    (last_survivor),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1])
			return d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return d[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] random_q16();
		logic signed [DATA_W-1:0] v;
		v = $urandom_range(4);
		case ($urandom_range(7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return (v - 2) <<< 16;
			default: return $urandom;
		endcase
	endfunction

	// plan: fill every entry the run would read but was never loaded, queue those loads,
	// and leave the fitness values untouched; otherwise predict the survivors
	function automatic void predict_selection(input bit plan);
		logic signed [DATA_W-1:0] saved [MAX_CAND];
		bit                       removed [MAX_CAND];
		logic signed [DATA_W-1:0] v;
		survivor_t                s;
		int n, keep, worst, rounds, last_idx;
		n = (cfg_total > MAX_CAND) ? MAX_CAND : cfg_total;
		keep = (cfg_keep > n) ? n : cfg_keep;
		removed = '{default: 1'b0};
		if (plan) begin
			for (int i = 0; i < n; i++) begin
				if (!fit_known[i]) begin
					v = random_q16();
					fit_mem[i] = v;
					fit_known[i] = 1'b1;
					pending_loads.push_back('{CMD_FIT, IDX_W'(i), IDX_W'($urandom), v});
				end
			end
			saved = fit_mem;
		end
		for (rounds = n - keep; rounds > 0; rounds--) begin
			worst = -1;
			for (int i = 0; i < n; i++)
				if (!removed[i] && (worst < 0 || fit_mem[i] > fit_mem[worst]))
					worst = i;
			if (worst < 0)
				break;
			for (int i = 0; i < n; i++) begin
				if (!removed[i]) begin
					if (plan && !corr_known[worst*MAX_CAND + i]) begin
						v = random_q16();
						corr_mem[worst*MAX_CAND + i] = v;
						corr_known[worst*MAX_CAND + i] = 1'b1;
						pending_loads.push_back('{CMD_MAT, IDX_W'(worst), IDX_W'(i), v});
					end
					fit_mem[i] = sat_sub(fit_mem[i], corr_mem[worst*MAX_CAND + i]);
				end
			end
			removed[worst] = 1'b1;
		end
		if (plan) begin
			fit_mem = saved;
			return;
		end
		last_idx = -1;
		for (int i = 0; i < n; i++)
			if (!removed[i])
				last_idx = i;
		for (int i = 0; i < n; i++) begin
			if (!removed[i]) begin
				s.idx = IDX_W'(i);
				s.fit = fit_mem[i];
				s.last = (i == last_idx);
				survivors_due.push_back(s);
			end
		end
		settle_cycles = (n - keep) * (2 * n + 4) + n + keep + 16;
	endfunction

	function automatic void record_transfer(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic signed [DATA_W-1:0] val);
		case (cmd)
			CMD_FIT: begin
				fit_mem[row] = val;
				fit_known[row] = 1'b1;
			end
			CMD_MAT: begin
				corr_mem[row*MAX_CAND + col] = val;
				corr_known[row*MAX_CAND + col] = 1'b1;
			end
			CMD_RUN: predict_selection(1'b0);
			default: ;
		endcase
	endfunction

	function automatic void flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $time, what);
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic signed [DATA_W-1:0] val);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		row_index <= row;
		col_index <= col;
		value     <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		record_transfer(cmd, row, col, val);
		if (cmd != CMD_NONE)
			items_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (survivors_due.size() != 0)
			@(posedge clk);
		repeat (settle_cycles) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TOTAL)
			cfg_total = data;
		else
			cfg_keep = data;
	endtask

	task automatic run_selection();
		load_t ld;
		predict_selection(1'b1);
		while (pending_loads.size() != 0) begin
			ld = pending_loads.pop_front();
			send_item(ld.cmd, ld.row, ld.col, ld.val);
		end
		send_item(CMD_RUN, IDX_W'($urandom), IDX_W'($urandom), $urandom);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// keep stays at its reset value, above the total: all survive
		write_reg(REG_TOTAL, 4);
		send_item(CMD_FIT, 0, 0, 32'sh7fffffff);
		send_item(CMD_FIT, 1, 63, 32'sh80000000);
		send_item(CMD_FIT, 2, 0, 32'sh00010000);
		send_item(CMD_FIT, 3, 0, 32'sh7fffffff);
		send_item(CMD_NONE, 0, 0, 32'sh12345678);
		run_selection();
		// tie on the max, then saturation both ways
		send_item(CMD_MAT, 0, 0, 32'shffffffff);
		send_item(CMD_MAT, 0, 1, 32'sh7fffffff);
		send_item(CMD_MAT, 0, 2, 32'sh00008000);
		send_item(CMD_MAT, 0, 3, 32'sh80000000);
		send_item(CMD_MAT, 63, 63, 32'sh7fffffff);
		send_item(CMD_NONE, 63, 63, 32'shffffffff);
		write_reg(REG_KEEP, 2);
		run_selection();
		write_reg(REG_KEEP, 4);
		run_selection();
		write_reg(REG_KEEP, 0);
		run_selection();
		write_reg(REG_TOTAL, 0);
		run_selection();
	endtask

	task automatic test_config_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_TOTAL, 7'h7f);
		write_reg(REG_KEEP, 7'h7f);
		run_selection();
		write_reg(REG_KEEP, 64);
		run_selection();
		write_reg(REG_TOTAL, 64);
		write_reg(REG_KEEP, 63);
		run_selection();
		write_reg(REG_TOTAL, 2);
		write_reg(REG_KEEP, 1);
		run_selection();
		write_reg(REG_KEEP, 0);
		run_selection();
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
			input int count);
		int goal, total, span;
		bit first;
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
		goal = items_sent + count;
		first = 1'b1;
		while (items_sent < goal) begin
			if (first || $urandom_range(2) == 0) begin
				total = $urandom_range(8);
				write_reg(REG_TOTAL, CFG_W'(total));
				write_reg(REG_KEEP, CFG_W'($urandom_range(total + 1)));
				first = 1'b0;
			end
			span = (cfg_total == 0) ? 1 : cfg_total;
			repeat ($urandom_range(6)) begin
				case ($urandom_range(9))
					0: send_item(CMD_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
					1: send_item(CMD_MAT, IDX_W'($urandom), IDX_W'($urandom), random_q16());
					2, 3, 4: send_item(CMD_FIT, IDX_W'($urandom_range(span - 1)),
						IDX_W'($urandom), random_q16());
					default: send_item(CMD_MAT, IDX_W'($urandom_range(span - 1)),
						IDX_W'($urandom_range(span - 1)), random_q16());
				endcase
			end
			run_selection();
		end
	endtask

	// output held off long enough that the block backs up onto its input
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_TOTAL, 8);
		write_reg(REG_KEEP, 8);
		hold_off = 300;
		repeat (4) begin
			repeat (3) send_item(CMD_FIT, IDX_W'($urandom_range(7)), IDX_W'($urandom),
				random_q16());
			run_selection();
		end
	endtask

	always @(posedge clk) begin : receiver
		survivor_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (survivors_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected survivor index %0d fitness %0d",
						survivor_index, survivor_fitness));
				end else begin
					want = survivors_due.pop_front();
					if (survivor_index !== want.idx)
						flag_mismatch($sformatf("survivor_index expected %0d got %0d",
							want.idx, survivor_index));
					if (survivor_fitness !== want.fit)
						flag_mismatch($sformatf("survivor_fitness expected %0d got %0d",
							want.fit, survivor_fitness));
					if (last_survivor !== want.last)
						flag_mismatch($sformatf("last_survivor expected %0b got %0b",
							want.last, last_survivor));
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_FIT;
		row_index = '0;
		col_index = '0;
		value = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TOTAL;
		cfg_data = '0;
		fit_known = '{default: 1'b0};
		corr_known = '{default: 1'b0};
		cfg_total = TOTAL_RST;
		cfg_keep = KEEP_RST;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		settle_cycles = 16;
		items_sent = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random_traffic(0, 0, 10);
		test_random_traffic(75, 0, 10);
		test_random_traffic(0, 75, 10);
		test_random_traffic(6, 6, 10);
		test_output_backpressure();

		in_valid <= 1'b0;
		while (survivors_due.size() != 0)
			@(posedge clk);
		repeat (settle_cycles) @(posedge clk);
		if (mismatches == 0 && survivors_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/isel_pkg.sv
hw/rtl/isel_unit.sv
hw/rtl/indicator_based_survivor_selection.sv
tb/sv/tb_top.sv
